### design/sxtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sxtok_pkg;

  // longest token, in characters
  localparam int unsigned MaxTokenLen = 1024;
  localparam int unsigned CountW      = 11;
  localparam logic [CountW-1:0] MaxTok = CountW'(MaxTokenLen);

  // result queue between scanner and output side
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;

  typedef enum logic [3:0] {
    K_EOF     = 4'd0,
    K_ERROR   = 4'd1,
    K_OPEN    = 4'd2,
    K_CLOSE   = 4'd3,
    K_SYMBOL  = 4'd4,
    K_STRING  = 4'd5,
    K_INTEGER = 4'd6,
    K_REAL    = 4'd7,
    K_PATTERN = 4'd8,
    K_DOT     = 4'd9,
    K_TRUE    = 4'd10,
    K_FALSE   = 4'd11
  } kind_e;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_STRING  = 4'd2,
    M_ESCAPE  = 4'd3,
    M_HASH    = 4'd4,
    M_HASHQ   = 4'd5,
    M_NUMBER  = 4'd6,
    M_DOTSEEN = 4'd7,
    M_SYMBOL  = 4'd8
  } mode_e;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    kind_e      token_kind;
    logic       token_done;
  } res_t;

  // all results caused by one input item
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  typedef struct packed {
    logic push;
    logic idle;
  } fstat_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= Ch0) && (c <= Ch9);
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return is_space(c) || (c == ChQuote) || (c == ChOpen) || (c == ChClose) ||
           (c == ChSemi);
  endfunction

  function automatic res_t mk_char(logic [7:0] c);
    res_t r;
    r            = '0;
    r.out_char   = c;
    r.char_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_done(kind_e k);
    res_t r;
    r            = '0;
    r.token_kind = k;
    r.token_done = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/sxtok_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sxtok_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_char_i,
  input  wire logic               in_eoi_i,
  input  wire logic               q_full_i,
  output logic                    in_ready_o,
  output sxtok_pkg::rec_t         rec_o,
  output sxtok_pkg::fstat_t       fstat_o
);

  typedef struct packed {
    sxtok_pkg::mode_e                mode;
    logic                            digit;
    logic                            other;
    logic [1:0]                      point;
    logic [sxtok_pkg::CountW-1:0]    tc;
  } scan_t;

  localparam scan_t ScanIdle = '{mode: sxtok_pkg::M_IDLE, digit: 1'b0, other: 1'b0,
                                 point: 2'd0, tc: '0};

  scan_t             st_q, st_d;
  logic              accept;
  logic              ok0, ok1;
  logic              is_sp, is_dg, is_tm;
  logic              mid_tok, known, do_start;
  logic [7:0]        esc_char;
  sxtok_pkg::kind_e  num_kind, end_kind;
  sxtok_pkg::res_t   res [2];
  logic [1:0]        cnt;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // room for one or two more characters in the current token
  assign ok0 = st_q.tc < sxtok_pkg::MaxTok;
  assign ok1 = (st_q.tc + sxtok_pkg::CountW'(1)) < sxtok_pkg::MaxTok;

  assign is_sp = sxtok_pkg::is_space(in_char_i);
  assign is_dg = sxtok_pkg::is_digit(in_char_i);
  assign is_tm = sxtok_pkg::is_term(in_char_i);

  assign mid_tok = (st_q.mode == sxtok_pkg::M_NUMBER) || (st_q.mode == sxtok_pkg::M_DOTSEEN) ||
                   (st_q.mode == sxtok_pkg::M_SYMBOL);
  assign known   = (st_q.mode != sxtok_pkg::M_IDLE) && (st_q.mode <= sxtok_pkg::M_SYMBOL);
  // delimiter ending a token is scanned again as the start of the next one
  assign do_start = !in_eoi_i && (mid_tok ? is_tm : !known);

  assign esc_char = (in_char_i == sxtok_pkg::ChLowN) ? sxtok_pkg::ChLf :
                    (in_char_i == sxtok_pkg::ChLowT) ? sxtok_pkg::ChTab : in_char_i;

  always_comb begin
    if (st_q.other || !st_q.digit || (st_q.point > 2'd1)) begin
      num_kind = sxtok_pkg::K_SYMBOL;
    end else if (st_q.point == 2'd1) begin
      num_kind = sxtok_pkg::K_REAL;
    end else begin
      num_kind = sxtok_pkg::K_INTEGER;
    end
  end

  always_comb begin
    unique case (st_q.mode)
      sxtok_pkg::M_NUMBER:  end_kind = num_kind;
      sxtok_pkg::M_DOTSEEN: end_kind = sxtok_pkg::K_DOT;
      sxtok_pkg::M_SYMBOL:  end_kind = sxtok_pkg::K_SYMBOL;
      default:              end_kind = sxtok_pkg::K_ERROR;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    if (in_eoi_i) begin
      st_d = ScanIdle;
    end else if (do_start) begin
      st_d = ScanIdle;
      case (in_char_i) inside
        sxtok_pkg::ChSemi:  st_d.mode = sxtok_pkg::M_COMMENT;
        sxtok_pkg::ChQuote: st_d.mode = sxtok_pkg::M_STRING;
        sxtok_pkg::ChHash:  st_d.mode = sxtok_pkg::M_HASH;
        sxtok_pkg::ChDot:   st_d.mode = sxtok_pkg::M_DOTSEEN;
        sxtok_pkg::ChOpen, sxtok_pkg::ChClose: ;
        default: begin
          if (!is_sp) begin
            if (is_dg || (in_char_i == sxtok_pkg::ChMinus)) begin
              st_d.mode  = sxtok_pkg::M_NUMBER;
              st_d.digit = is_dg;
            end else begin
              st_d.mode = sxtok_pkg::M_SYMBOL;
            end
            st_d.tc = sxtok_pkg::CountW'(1);
          end
        end
      endcase
    end else begin
      unique case (st_q.mode)
        sxtok_pkg::M_COMMENT: begin
          if (in_char_i == sxtok_pkg::ChLf) st_d = ScanIdle;
        end
        sxtok_pkg::M_STRING: begin
          if (in_char_i == sxtok_pkg::ChQuote) begin
            st_d = ScanIdle;
          end else if (in_char_i == sxtok_pkg::ChBslash) begin
            st_d.mode = sxtok_pkg::M_ESCAPE;
          end else if (ok0) begin
            st_d.tc = st_q.tc + sxtok_pkg::CountW'(1);
          end else begin
            st_d = ScanIdle;
          end
        end
        sxtok_pkg::M_ESCAPE: begin
          if (ok0) begin
            st_d.mode = sxtok_pkg::M_STRING;
            st_d.tc   = st_q.tc + sxtok_pkg::CountW'(1);
          end else begin
            st_d = ScanIdle;
          end
        end
        sxtok_pkg::M_HASH: begin
          if (in_char_i == sxtok_pkg::ChQmark) begin
            st_d.mode = sxtok_pkg::M_HASHQ;
          end else begin
            st_d = ScanIdle;
          end
        end
        sxtok_pkg::M_HASHQ: st_d = ScanIdle;
        sxtok_pkg::M_NUMBER: begin
          if (ok0) begin
            if (is_dg) begin
              st_d.digit = 1'b1;
            end else if (in_char_i == sxtok_pkg::ChDot) begin
              if (st_q.point < 2'd2) st_d.point = st_q.point + 2'd1;
            end else begin
              st_d.other = 1'b1;
            end
            st_d.tc = st_q.tc + sxtok_pkg::CountW'(1);
          end else begin
            st_d = ScanIdle;
          end
        end
        sxtok_pkg::M_DOTSEEN: begin
          // leading dot plus this character become a symbol
          if (ok0 && ok1) begin
            st_d.mode = sxtok_pkg::M_SYMBOL;
            st_d.tc   = st_q.tc + sxtok_pkg::CountW'(2);
          end else begin
            st_d = ScanIdle;
          end
        end
        sxtok_pkg::M_SYMBOL: begin
          if (ok0) begin
            st_d.tc = st_q.tc + sxtok_pkg::CountW'(1);
          end else begin
            st_d = ScanIdle;
          end
        end
        default: st_d = ScanIdle;
      endcase
    end
  end

  // results of this item
  always_comb begin
    cnt    = 2'd0;
    res[0] = '0;
    res[1] = '0;
    if (in_eoi_i) begin
      if (known && (st_q.mode != sxtok_pkg::M_COMMENT)) begin
        res[cnt[0]] = sxtok_pkg::mk_done(end_kind);
        cnt = cnt + 2'd1;
      end
      res[cnt[0]] = sxtok_pkg::mk_done(sxtok_pkg::K_EOF);
      cnt = cnt + 2'd1;
    end else if (do_start) begin
      if (mid_tok) begin
        res[cnt[0]] = sxtok_pkg::mk_done(end_kind);
        cnt = cnt + 2'd1;
      end
      case (in_char_i) inside
        sxtok_pkg::ChOpen: begin
          res[cnt[0]] = sxtok_pkg::mk_done(sxtok_pkg::K_OPEN);
          cnt = cnt + 2'd1;
        end
        sxtok_pkg::ChClose: begin
          res[cnt[0]] = sxtok_pkg::mk_done(sxtok_pkg::K_CLOSE);
          cnt = cnt + 2'd1;
        end
        sxtok_pkg::ChSemi, sxtok_pkg::ChQuote, sxtok_pkg::ChHash, sxtok_pkg::ChDot: ;
        default: begin
          if (!is_sp) begin
            res[cnt[0]] = sxtok_pkg::mk_char(in_char_i);
            cnt = cnt + 2'd1;
          end
        end
      endcase
    end else begin
      unique case (st_q.mode)
        sxtok_pkg::M_STRING: begin
          if (in_char_i == sxtok_pkg::ChQuote) begin
            res[0] = sxtok_pkg::mk_done(sxtok_pkg::K_STRING);
            cnt    = 2'd1;
          end else if (in_char_i != sxtok_pkg::ChBslash) begin
            res[0] = ok0 ? sxtok_pkg::mk_char(in_char_i) :
                           sxtok_pkg::mk_done(sxtok_pkg::K_ERROR);
            cnt    = 2'd1;
          end
        end
        sxtok_pkg::M_ESCAPE: begin
          res[0] = ok0 ? sxtok_pkg::mk_char(esc_char) : sxtok_pkg::mk_done(sxtok_pkg::K_ERROR);
          cnt    = 2'd1;
        end
        sxtok_pkg::M_HASH: begin
          if (in_char_i == sxtok_pkg::ChLowT) begin
            res[0] = sxtok_pkg::mk_done(sxtok_pkg::K_TRUE);
            cnt    = 2'd1;
          end else if (in_char_i == sxtok_pkg::ChLowF) begin
            res[0] = sxtok_pkg::mk_done(sxtok_pkg::K_FALSE);
            cnt    = 2'd1;
          end else if (in_char_i != sxtok_pkg::ChQmark) begin
            res[0] = sxtok_pkg::mk_done(sxtok_pkg::K_ERROR);
            cnt    = 2'd1;
          end
        end
        sxtok_pkg::M_HASHQ: begin
          res[0] = sxtok_pkg::mk_done((in_char_i == sxtok_pkg::ChOpen) ? sxtok_pkg::K_PATTERN :
                                                                         sxtok_pkg::K_ERROR);
          cnt    = 2'd1;
        end
        sxtok_pkg::M_NUMBER, sxtok_pkg::M_SYMBOL: begin
          res[0] = ok0 ? sxtok_pkg::mk_char(in_char_i) : sxtok_pkg::mk_done(sxtok_pkg::K_ERROR);
          cnt    = 2'd1;
        end
        sxtok_pkg::M_DOTSEEN: begin
          if (!ok0) begin
            res[0] = sxtok_pkg::mk_done(sxtok_pkg::K_ERROR);
            cnt    = 2'd1;
          end else begin
            res[0] = sxtok_pkg::mk_char(sxtok_pkg::ChDot);
            res[1] = ok1 ? sxtok_pkg::mk_char(in_char_i) : sxtok_pkg::mk_done(sxtok_pkg::K_ERROR);
            cnt    = 2'd2;
          end
        end
        default: ;
      endcase
    end
  end

  assign rec_o.two    = (cnt == 2'd2);
  assign rec_o.r0     = res[0];
  assign rec_o.r1     = res[1];
  assign fstat_o.push = accept && (cnt != 2'd0);
  assign fstat_o.idle = (st_q.mode == sxtok_pkg::M_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ScanIdle;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

### design/sxtok_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sxtok_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire sxtok_pkg::rec_t    rec_i,
  input  wire logic               pop_i,
  output sxtok_pkg::rec_t         head_o,
  output logic                    empty_o,
  output logic                    full_o
);

  sxtok_pkg::rec_t                 mem_q [sxtok_pkg::QDepth];
  logic [sxtok_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [sxtok_pkg::QPtrW:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (sxtok_pkg::QPtrW + 1)'(sxtok_pkg::QDepth));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (sxtok_pkg::QPtrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (sxtok_pkg::QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + sxtok_pkg::QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + sxtok_pkg::QPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### design/sxtok_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sxtok_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sxtok_pkg::rec_t    head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [7:0]              m_data_o,
  output logic [5:0]              m_user_o,
  output logic                    m_last_o
);

  logic            phase_q, phase_d;
  logic            fire;
  sxtok_pkg::res_t cur;

  // second result of a two-result record goes out after the first
  assign cur       = phase_q ? head_i.r1 : head_i.r0;
  assign m_valid_o = !empty_i;
  assign m_last_o  = !head_i.two || phase_q;
  assign m_data_o  = cur.out_char;
  assign m_user_o  = {cur.token_done, cur.token_kind, cur.char_valid};
  assign fire      = m_valid_o && m_ready_i;
  assign pop_o     = fire && m_last_o;

  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      phase_d = !m_last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

### design/sexpr_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// s-expression tokenizer
// input stream: one item per text byte on s_axis_tdata; s_axis_tlast high marks
//   end of text (tdata then ignored), which closes any open token and emits eof
// output stream: one item per token character or finished token; tdata is the
//   character, tuser holds char_valid, token_kind and token_done, and tlast
//   flags the final output item caused by one input item
// an input item gives zero, one or two output items; white space between tokens
//   and comment text give none and are simply absorbed
// results of a taken item are registered in the queue and presented from its head
// throughput: one input item per clock while the queue is not full; the scanner
//   state updates once per byte taken, and the output side sends one item per
//   clock while the receiver is ready, so an item's two results go out in turn
// a four-entry record queue sits between the scanner and the output side, so
//   input keeps flowing while results wait; when the receiver stalls the queue
//   fills and s_axis_tready drops only once all four entries are taken
// reset: scanner idle between tokens, queue empty, no output pending; there is
//   no clearing pass, the block takes items right after reset
module sexpr_tokenizer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic       s_axis_tlast,   // end_of_input
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [5:0]      m_axis_tuser,   // [0] char_valid, [4:1] token_kind, [5] token_done
  output logic            m_axis_tlast    // last
);

  sxtok_pkg::rec_t   rec, head;
  sxtok_pkg::fstat_t fstat;
  logic              q_full, q_empty, pop;

  // front: byte classification and scanner state
  sxtok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_char_i  (s_axis_tdata),
    .in_eoi_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .rec_o      (rec),
    .fstat_o    (fstat)
  );

  // records of one or two results per input item
  sxtok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fstat.push),
    .rec_i   (rec),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: serializes each record onto the output stream
  sxtok_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .empty_i   (q_empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  // end of text always produces at least the eof result
  a_eoi_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> fstat.push)
    else $error("end of text gave no result");

  // scanner is back between tokens after end of text
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> fstat.idle)
    else $error("scanner not idle after end of text");

  // each output item is either a character or a token end, never both
  a_res_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tuser[5]))
    else $error("malformed output item");

endmodule
`default_nettype wire
